// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/csru_pkg.sv =====
// package for the chunk sample-rate upconverter: widths, codes and payload types
`default_nettype none

package csru_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned IN_COUNT_W  = 13;
  localparam int unsigned OUT_COUNT_W = 14;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 14;

  localparam int unsigned MAX_CHUNK_SAMPLES = 4096;

  localparam logic [IN_COUNT_W-1:0]  IN_COUNT_RST  = IN_COUNT_W'(441);
  localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_RST = OUT_COUNT_W'(480);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       inserted;
    logic                       chunk_end;
    logic                       bad_ratio;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chunk_sample_rate_upconverter_unit.sv =====
// chunk sample-rate upconverter: sequencer, serial divider and output queue
// pass-through or insertion result is pushed from ST_INS; the copied sample follows from
// ST_COPY after ST_LOAD, ST_RUN and, when a new run starts, the 14-step serial divider
// a new sample is accepted only in ST_IDLE, after the previous one is finished
// bad counts: ST_INS passes the sample; input waits while the 4-entry queue holds over 2
// reset: counts return to 441 and 480, chunk state and previous sample clear to zero
`default_nettype none

`include "assert_macros.svh"

module chunk_sample_rate_upconverter_unit #(
  parameter int unsigned MAX_CHUNK_SAMPLES = csru_pkg::MAX_CHUNK_SAMPLES
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // sample input
  input  wire logic                                 in_valid_i,
  output      logic                                 in_ready_o,
  input  wire csru_pkg::in_t                        in_data_i,
  // result output
  output      logic                                 out_valid_o,
  input  wire logic                                 out_ready_i,
  output      csru_pkg::out_t                       out_data_o,
  // configuration writes
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic [csru_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [csru_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned SW = csru_pkg::SAMPLE_W;
  localparam int unsigned IW = csru_pkg::IN_COUNT_W;
  localparam int unsigned OW = csru_pkg::OUT_COUNT_W;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a sample
  localparam logic [2:0] ST_INS  = 3'd1;  // pass-through or pending insertion
  localparam logic [2:0] ST_LOAD = 3'd2;  // open a new chunk if needed
  localparam logic [2:0] ST_RUN  = 3'd3;  // decide on a new run
  localparam logic [2:0] ST_DIV  = 3'd4;  // serial divide for the run length
  localparam logic [2:0] ST_COPY = 3'd5;  // emit the copied sample

  // output queue: an item pushes at most two results
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam int unsigned DIV_STEPS = OW;
  localparam int unsigned DCW       = $clog2(DIV_STEPS);

  // averaging of two samples, truncated toward zero
  function automatic logic [SW-1:0] avg2(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    logic [SW:0] t;
    s = {a[SW-1], a} + {b[SW-1], b};
    t = s + {{SW{1'b0}}, s[SW]};
    return t[SW:1];
  endfunction

  logic [2:0]    state_q, state_d;

  // configuration registers
  logic [IW-1:0] in_count_q;
  logic [OW-1:0] out_count_q;
  logic          bad;

  // chunk state
  logic [SW-1:0] prev_left_q, prev_right_q;
  logic [IW-1:0] in_left_q;
  logic [OW-1:0] out_left_q;
  logic [OW-1:0] run_left_q;
  logic          insert_due_q;
  logic          copy_rest_q;

  // latched sample under work
  csru_pkg::in_t x_q;

  // serial divider
  logic [OW-1:0]  div_rem_q, div_quo_q, div_v_q;
  logic [OW-1:0]  div_quo_d;
  logic [DCW-1:0] div_cnt_q;
  logic [OW:0]    div_trial, div_sub;
  logic           div_ge;

  // output queue
  csru_pkg::out_t   q_mem [QDEPTH];
  logic [QPW-1:0]   q_wr_q, q_rd_q;
  logic [QCW-1:0]   q_cnt_q;
  logic             push, pop;
  csru_pkg::out_t   push_data;

  // helper values
  logic [OW-1:0] out_left_ins;   // out_left after an insertion
  logic [OW-1:0] out_left_cpy;   // out_left after the copy
  logic [OW-1:0] run_left_cpy;
  logic [OW-1:0] run_len;
  logic          in_acc, cfg_acc;

  assign bad = (in_count_q == '0) ||
               (32'(in_count_q) > 32'(MAX_CHUNK_SAMPLES)) ||
               (out_count_q <= {1'b0, in_count_q}) ||
               (out_count_q > {in_count_q, 1'b0});

  assign in_ready_o  = (state_q == ST_IDLE) && (q_cnt_q <= QCW'(QDEPTH - 2));
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  assign out_left_ins = (out_left_q != '0) ? out_left_q - OW'(1) : out_left_q;
  assign out_left_cpy = out_left_q - OW'(1);
  assign run_left_cpy = run_left_q - OW'(1);
  // run of copies is one less than the quotient, but never zero
  // taken from the quotient as it stands after the last divide step
  assign run_len      = (div_quo_d > OW'(1)) ? div_quo_d - OW'(1) : OW'(1);

  // one restoring divide step per cycle
  assign div_trial = {div_rem_q, div_quo_q[OW-1]};
  assign div_sub   = div_trial - {1'b0, div_v_q};
  assign div_ge    = (div_trial >= {1'b0, div_v_q});
  assign div_quo_d = {div_quo_q[OW-2:0], div_ge};

  // sequencer and result selection
  always_comb begin
    state_d   = state_q;
    push      = 1'b0;
    push_data = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_INS;
      end
      ST_INS: begin
        if (bad) begin
          push                = 1'b1;
          push_data.left_out  = x_q.left_in;
          push_data.right_out = x_q.right_in;
          push_data.bad_ratio = 1'b1;
          state_d             = ST_IDLE;
        end else begin
          if (insert_due_q) begin
            push                = 1'b1;
            push_data.left_out  = avg2(prev_left_q, x_q.left_in);
            push_data.right_out = avg2(prev_right_q, x_q.right_in);
            push_data.inserted  = 1'b1;
            push_data.chunk_end = (out_left_ins == '0);
          end
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_RUN;
      ST_RUN: begin
        if (!copy_rest_q && (run_left_q == '0) && (out_left_q > {1'b0, in_left_q})) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_COPY;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == DCW'(DIV_STEPS - 1)) state_d = ST_COPY;
      end
      ST_COPY: begin
        push                = 1'b1;
        push_data.left_out  = x_q.left_in;
        push_data.right_out = x_q.right_in;
        push_data.chunk_end = (out_left_cpy == '0);
        state_d             = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      in_count_q   <= csru_pkg::IN_COUNT_RST;
      out_count_q  <= csru_pkg::OUT_COUNT_RST;
      prev_left_q  <= '0;
      prev_right_q <= '0;
      in_left_q    <= '0;
      out_left_q   <= '0;
      run_left_q   <= '0;
      insert_due_q <= 1'b0;
      copy_rest_q  <= 1'b0;
      div_cnt_q    <= '0;
    end else begin
      state_q <= state_d;

      // a write to either count register abandons the open chunk
      if (cfg_acc) begin
        unique case (cfg_index_i)
          csru_pkg::CFG_IN_COUNT: begin
            in_count_q   <= cfg_data_i[IW-1:0];
            in_left_q    <= '0;
            out_left_q   <= '0;
            run_left_q   <= '0;
            insert_due_q <= 1'b0;
            copy_rest_q  <= 1'b0;
          end
          csru_pkg::CFG_OUT_COUNT: begin
            out_count_q  <= cfg_data_i[OW-1:0];
            in_left_q    <= '0;
            out_left_q   <= '0;
            run_left_q   <= '0;
            insert_due_q <= 1'b0;
            copy_rest_q  <= 1'b0;
          end
          default: ;
        endcase
      end

      unique case (state_q)
        ST_INS: begin
          if (bad) begin
            prev_left_q  <= x_q.left_in;
            prev_right_q <= x_q.right_in;
          end else if (insert_due_q) begin
            insert_due_q <= 1'b0;
            out_left_q   <= out_left_ins;
          end
        end
        ST_LOAD: begin
          if (out_left_q == '0) begin
            in_left_q   <= in_count_q;
            out_left_q  <= out_count_q;
            run_left_q  <= '0;
            copy_rest_q <= 1'b0;
          end
        end
        ST_RUN: begin
          div_cnt_q <= '0;
          if (!copy_rest_q && (run_left_q == '0) && (out_left_q <= {1'b0, in_left_q})) begin
            copy_rest_q <= 1'b1;
          end
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == DCW'(DIV_STEPS - 1)) run_left_q <= run_len;
        end
        ST_COPY: begin
          if (in_left_q != '0) in_left_q <= in_left_q - IW'(1);
          out_left_q   <= out_left_cpy;
          prev_left_q  <= x_q.left_in;
          prev_right_q <= x_q.right_in;
          if (!copy_rest_q) begin
            if (out_left_cpy == '0) begin
              run_left_q <= '0;
            end else begin
              run_left_q <= run_left_cpy;
              if (run_left_cpy == '0) insert_due_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // sample latch and divider datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) x_q <= in_data_i;
    if (state_q == ST_RUN) begin
      div_rem_q <= '0;
      div_quo_q <= out_left_q;
      div_v_q   <= out_left_q - {1'b0, in_left_q};
    end else if (state_q == ST_DIV) begin
      div_rem_q <= div_ge ? div_sub[OW-1:0] : div_trial[OW-1:0];
      div_quo_q <= div_quo_d;
    end
  end

  // output queue
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (q_cnt_q != '0);
  assign out_data_o  = q_mem[q_rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[q_wr_q] <= push_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (push) q_wr_q <= q_wr_q + QPW'(1);
      if (pop)  q_rd_q <= q_rd_q + QPW'(1);
      if (push && !pop)      q_cnt_q <= q_cnt_q + QCW'(1);
      else if (pop && !push) q_cnt_q <= q_cnt_q - QCW'(1);
    end
  end

  // checks
  `ASSERT_NEVER(a_queue_overflow, push && !pop && (q_cnt_q == QCW'(QDEPTH)), "output queue overflow")
  `ASSERT_HOLDS(a_accept_starts, in_acc |=> (state_q == ST_INS), "accepted sample not processed")
  `ASSERT_NEVER(a_div_zero, (state_q == ST_DIV) && (div_v_q == '0), "run divider with zero divisor")
  `ASSERT_NEVER(a_run_wrap, (state_q == ST_COPY) && !copy_rest_q && (run_left_q == '0), "run count would wrap")

endmodule

`default_nettype wire

// ===== tb/csru_checker.sv =====
// checker for the chunk sample-rate upconverter: predicts every result and compares it
module csru_checker
  import csru_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_t                  out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    insertions_o,
  output int                    chunk_ends_o,
  output int                    passthru_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor copy of the counts and the chunk state
  logic [IN_COUNT_W-1:0]      in_count_q;
  logic [OUT_COUNT_W-1:0]     out_count_q;
  logic signed [SAMPLE_W-1:0] last_left;
  logic signed [SAMPLE_W-1:0] last_right;
  logic [IN_COUNT_W-1:0]      ins_to_go;
  logic [OUT_COUNT_W-1:0]     outs_to_go;
  logic [OUT_COUNT_W-1:0]     run_to_go;
  logic                       insert_waiting;
  logic                       straight_copy;

  out_t upsampled_q[$];
  int   mismatches;
  int   results;
  int   insertions;
  int   chunk_ends;
  int   passthru;

  function automatic logic counts_invalid();
    int unsigned ic;
    int unsigned oc;
    ic = in_count_q;
    oc = out_count_q;
    return ic < 1 || ic > MAX_CHUNK_SAMPLES || oc <= ic || oc > 2 * ic;
  endfunction

  // average of two samples, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] midpoint(logic signed [SAMPLE_W-1:0] a,
                                                          logic signed [SAMPLE_W-1:0] b);
    int sum;
    sum = int'(a) + int'(b);
    return SAMPLE_W'(sum / 2);
  endfunction

  function automatic string show(out_t r);
    return $sformatf("L=%0d R=%0d ins=%0b end=%0b bad=%0b", r.left_out, r.right_out,
                     r.inserted, r.chunk_end, r.bad_ratio);
  endfunction

  task automatic clear_chunk();
    ins_to_go      = '0;
    outs_to_go     = '0;
    run_to_go      = '0;
    insert_waiting = 1'b0;
    straight_copy  = 1'b0;
  endtask

  task automatic upconvert_sample(input in_t s);
    out_t        r;
    int unsigned span;
    int unsigned quot;
    if (counts_invalid()) begin
      r = '{left_out: s.left_in, right_out: s.right_in, inserted: 1'b0, chunk_end: 1'b0,
            bad_ratio: 1'b1};
      upsampled_q = {upsampled_q, r};
    end else begin
      // insertion held over from the previous run goes out first
      if (insert_waiting) begin
        insert_waiting = 1'b0;
        if (outs_to_go != 0) outs_to_go--;
        r = '{left_out: midpoint(last_left, s.left_in),
              right_out: midpoint(last_right, s.right_in),
              inserted: 1'b1, chunk_end: outs_to_go == 0, bad_ratio: 1'b0};
        upsampled_q = {upsampled_q, r};
      end
      if (outs_to_go == 0) begin
        ins_to_go     = in_count_q;
        outs_to_go    = out_count_q;
        run_to_go     = '0;
        straight_copy = 1'b0;
      end
      if (!straight_copy && run_to_go == 0) begin
        if (outs_to_go <= ins_to_go) begin
          straight_copy = 1'b1;
        end else begin
          span      = outs_to_go - ins_to_go;
          quot      = outs_to_go / span;
          run_to_go = (quot > 1) ? OUT_COUNT_W'(quot - 1) : OUT_COUNT_W'(1);
        end
      end
      if (ins_to_go != 0) ins_to_go--;
      outs_to_go--;
      r = '{left_out: s.left_in, right_out: s.right_in, inserted: 1'b0,
            chunk_end: outs_to_go == 0, bad_ratio: 1'b0};
      upsampled_q = {upsampled_q, r};
      if (!straight_copy) begin
        run_to_go--;
        if (outs_to_go == 0) run_to_go = '0;
        else if (run_to_go == 0) insert_waiting = 1'b1;
      end
    end
    last_left  = s.left_in;
    last_right = s.right_in;
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    results++;
    if (upsampled_q.size() == 0) begin
      note_mismatch($sformatf("result with nothing expected: %s", show(got)));
    end else begin
      want = upsampled_q.pop_front();
      if (want.inserted) insertions++;
      if (want.chunk_end) chunk_ends++;
      if (want.bad_ratio) passthru++;
      if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
          got.inserted !== want.inserted || got.chunk_end !== want.chunk_end ||
          got.bad_ratio !== want.bad_ratio)
        note_mismatch($sformatf("expected %s, got %s", show(want), show(got)));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  = IN_COUNT_RST;
      out_count_q = OUT_COUNT_RST;
      last_left   = '0;
      last_right  = '0;
      clear_chunk();
      upsampled_q.delete();
      mismatches  = 0;
      results     = 0;
      insertions  = 0;
      chunk_ends  = 0;
      passthru    = 0;
    end else begin
      // a count write drops the open chunk, the previous sample stays
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IN_COUNT: begin
            in_count_q = cfg_data_i[IN_COUNT_W-1:0];
            clear_chunk();
          end
          CFG_OUT_COUNT: begin
            out_count_q = cfg_data_i[OUT_COUNT_W-1:0];
            clear_chunk();
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) upconvert_sample(in_data_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
    end
    mismatches_o <= mismatches;
    pending_o    <= upsampled_q.size();
    results_o    <= results;
    insertions_o <= insertions;
    chunk_ends_o <= chunk_ends;
    passthru_o   <= passthru;
  end

endmodule

// ===== tb/tb_chunk_sample_rate_upconverter_unit.sv =====
// testbench top for the chunk sample-rate upconverter: clock, reset, stimulus and verdict
module tb_chunk_sample_rate_upconverter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import csru_pkg::*;

  localparam int RANDOM_ITEMS  = 1150;
  localparam int SETTLE_CYCLES = 40;    // covers the serial divider after the last result
  localparam int HOLD_CYCLES   = 400;   // long receiver back-pressure
  localparam int STALL_LIMIT   = 5000;  // cycles with no transaction at all
  localparam int IDLE_PCT      = 9;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int pending;
  int results;
  int insertions;
  int chunk_ends;
  int passthru;

  // traffic shaping flags shared between the sender and the receiver
  bit calm        = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_served = 1'b0;

  int samples_sent  = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  chunk_sample_rate_upconverter_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  csru_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .insertions_o (insertions),
    .chunk_ends_o (chunk_ends),
    .passthru_o   (passthru)
  );

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("[chunk_sample_rate_upconverter_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, none while calm, and one long hold on request
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        // sender keeps offering, so the output queue fills and input stalls
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = 1'b1;
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // one sample transaction, with a random gap ahead of it unless calm
  task automatic send_sample(input in_t s);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic send_lr(input int l, input int r);
    in_t s;
    s.left_in  = SAMPLE_W'(l);
    s.right_in = SAMPLE_W'(r);
    send_sample(s);
  endtask

  // valid stays high across back-to-back writes; the last one lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // stop sending, wait for every predicted result, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sample level: full range in four cases of ten, else extremes, zero, all ones or small values from -8 to 8
  function automatic logic [SAMPLE_W-1:0] pick_level();
    case ($urandom_range(9))
      0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      4, 5:    return SAMPLE_W'($urandom_range(16) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic in_t random_sample();
    in_t s;
    s.left_in  = pick_level();
    s.right_in = pick_level();
    return s;
  endfunction

  // count settings: small valid chunks nearly half the time, plus larger ones, extremes and bad ratios
  task automatic pick_counts(output logic [IN_COUNT_W-1:0] ic,
                             output logic [OUT_COUNT_W-1:0] oc);
    int unsigned a;
    a = $urandom_range(1, 24);
    case ($urandom_range(19))
      9: begin
        a  = $urandom_range(25, 600);
        ic = IN_COUNT_W'(a);
        oc = OUT_COUNT_W'($urandom_range(a + 1, 2 * a));
      end
      10: begin ic = IN_COUNT_W'(1);    oc = OUT_COUNT_W'(2);    end
      11: begin ic = IN_COUNT_W'(4096); oc = OUT_COUNT_W'(8192); end
      12: begin ic = IN_COUNT_W'(4096); oc = OUT_COUNT_W'(4097); end
      13: begin ic = IN_COUNT_W'(441);  oc = OUT_COUNT_W'(480);  end
      14: begin ic = '0; oc = OUT_COUNT_W'($urandom_range(16383)); end
      15: begin
        ic = IN_COUNT_W'($urandom_range(4097, 8191));
        oc = OUT_COUNT_W'($urandom_range(16383));
      end
      16: begin ic = IN_COUNT_W'(a); oc = OUT_COUNT_W'(a); end
      17: begin ic = IN_COUNT_W'(a); oc = OUT_COUNT_W'(2 * a + 1); end
      18: begin ic = IN_COUNT_W'(a); oc = $urandom_range(1) ? '0 : '1; end
      19: begin ic = '1; oc = '1; end
      default: begin
        ic = IN_COUNT_W'(a);
        oc = OUT_COUNT_W'($urandom_range(a + 1, 2 * a));
      end
    endcase
  endtask

  initial begin
    logic [IN_COUNT_W-1:0]  ic;
    logic [OUT_COUNT_W-1:0] oc;
    int                     n;
    int                     random_sent;
    int                     failures;

    random_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset counts, full-scale samples
    send_lr(32767, -32768);
    send_lr(-32768, 32767);
    drain_results();

    // ratio of exactly two: an insertion after every sample, the chunk's last one
    // waits for the next chunk's first sample; top data bit is ignored by in_count
    write_reg(CFG_IN_COUNT, {1'b1, IN_COUNT_W'(2)}, 1'b1);
    write_reg(CFG_OUT_COUNT, CFG_DATA_W'(4), 1'b0);
    settings_used++;
    send_lr(32767, -32768);
    send_lr(32767, -32768);
    send_lr(-32768, 32767);
    send_lr(-3, 3);
    send_lr(0, 0);
    send_lr(-1, 1);
    send_lr(1, -1);
    send_lr(0, -32768);
    drain_results();

    // smallest valid chunk, out written first
    write_reg(CFG_OUT_COUNT, CFG_DATA_W'(2), 1'b1);
    write_reg(CFG_IN_COUNT, CFG_DATA_W'(1), 1'b0);
    settings_used++;
    send_lr(5, -5);
    send_lr(-5, 5);
    send_lr(7, -7);
    drain_results();

    // bad ratios: equal counts, then more than twice
    write_reg(CFG_IN_COUNT, CFG_DATA_W'(5), 1'b1);
    write_reg(CFG_OUT_COUNT, CFG_DATA_W'(5), 1'b0);
    send_lr(-32768, -32768);
    send_lr(32767, 32767);
    drain_results();
    write_reg(CFG_OUT_COUNT, CFG_DATA_W'(11), 1'b0);
    settings_used += 2;
    send_lr(123, -456);
    send_lr(-1, -1);
    drain_results();

    // undecoded indexes must change nothing, then an uneven ratio
    write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom), 1'b1);
    write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom), 1'b1);
    write_reg(CFG_IN_COUNT, CFG_DATA_W'(3), 1'b1);
    write_reg(CFG_OUT_COUNT, CFG_DATA_W'(5), 1'b0);
    settings_used++;
    send_lr(100, -100);
    send_lr(-101, 101);
    send_lr(32767, -32768);
    send_lr(-32767, 32766);
    drain_results();

    // random phases, each ending with a full drain before the next write
    while (random_sent < RANDOM_ITEMS) begin
      pick_counts(ic, oc);
      // now and then keep the open chunk running across the phase boundary
      if ($urandom_range(7) != 0) begin
        if ($urandom_range(5) == 0)
          write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_DATA_W'($urandom), 1'b1);
        if ($urandom_range(1)) begin
          write_reg(CFG_IN_COUNT, {1'($urandom), ic}, 1'b1);
          write_reg(CFG_OUT_COUNT, oc, 1'b0);
        end else begin
          write_reg(CFG_OUT_COUNT, oc, 1'b1);
          write_reg(CFG_IN_COUNT, {1'($urandom), ic}, 1'b0);
        end
        settings_used++;
      end
      n = (ic >= MAX_CHUNK_SAMPLES) ? $urandom_range(10, 30) : $urandom_range(20, 90);
      // no idling on either side through the middle of the run
      calm = (random_sent >= 500 && random_sent < 700);
      // one long receiver hold while this phase keeps the input busy
      if (!hold_req && random_sent >= 250) begin
        hold_req = 1'b1;
        n        = 80;
      end
      repeat (n) send_sample(random_sample());
      drain_results();
      random_sent += n;
    end
    calm = 1'b0;

    failures = mismatches + pending;
    $display("run covered %0d samples and %0d results: %0d inserted, %0d chunk ends, %0d bad ratio",
             samples_sent, results, insertions, chunk_ends, passthru);
    $display("across %0d count settings, with one %0d-cycle receiver hold",
             settings_used, HOLD_CYCLES);
    if (failures == 0) begin
      $display("[chunk_sample_rate_upconverter_unit] OK");
    end else begin
      $display("[chunk_sample_rate_upconverter_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/csru_pkg.sv
hw/rtl/chunk_sample_rate_upconverter_unit.sv
tb/csru_checker.sv
tb/tb_chunk_sample_rate_upconverter_unit.sv
